FILE: src/sfq_pkg.sv
package sfq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int FIELD_WIDTH  = 32;
    localparam int KIND_WIDTH   = 3;
    localparam int STATUS_WIDTH = 3;

    localparam logic [KIND_WIDTH-1:0] REQ_INSERT  = 3'd0;
    localparam logic [KIND_WIDTH-1:0] REQ_SEARCH  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] REQ_MODIFY  = 3'd2;
    localparam logic [KIND_WIDTH-1:0] REQ_DELETE  = 3'd3;
    localparam logic [KIND_WIDTH-1:0] REQ_DISPLAY = 3'd4;

    localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd4;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic modify;
        logic remove;
        logic rotate;
    } cell_ctrl_t;

endpackage

FILE: src/sfq_cell.sv
module sfq_cell #(
    parameter int DATA_WIDTH  = sfq_pkg::DATA_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = 5,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  sfq_pkg::cell_ctrl_t    ctrl,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [DATA_WIDTH-1:0]  key,
    input  logic [DATA_WIDTH-1:0]  repl,
    input  logic [DATA_WIDTH-1:0]  head,
    input  logic [DATA_WIDTH-1:0]  behind,
    input  logic                   match_in,
    output logic                   match_out,
    output logic [DATA_WIDTH-1:0]  data
);

    localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occupied;
    logic                  hit;
    logic                  is_tail;

    assign occupied  = MY_INDEX < count;
    assign hit       = occupied && (data_reg == key);
    assign is_tail   = occupied && (MY_INDEX == count - COUNT_WIDTH'(1));
    assign match_out = match_in | hit;
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert && (MY_INDEX == count))
        begin
            data_next = key;
        end
        else if (ctrl.modify && hit && !match_in)
        begin
            data_next = repl;
        end
        else if (ctrl.remove && match_out)
        begin
            // close the gap: take the neighbour's entry
            data_next = behind;
        end
        else if (ctrl.rotate && occupied)
        begin
            // head wraps round to the tail while the display streams
            data_next = is_tail ? head : behind;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: src/searchable_fifo_queue_unit.sv
// Searchable FIFO of DEPTH signed entries kept in arrival order in a chain of
// cells. Search, modify and delete compare the key in every cell at once and
// the first match is picked by a ripple through the chain. Insert, search,
// modify and delete each give one result, in the cycle after it is accepted.
// Display rotates the chain by one cell a cycle while the output is not stalled
// and emits one result per entry, head first, the last marked by last_result
// (one EMPTY result for an empty queue); it holds off new requests until its
// last entry is emitted. Request kinds 5 to 7 are taken and ignored and give no
// result. Entries hold no reset value; only the occupied ones are ever read.
module searchable_fifo_queue_unit #(
    parameter int DEPTH      = sfq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [sfq_pkg::KIND_WIDTH-1:0]         req_type,
    input  logic signed [sfq_pkg::FIELD_WIDTH-1:0] key_value,
    input  logic signed [sfq_pkg::FIELD_WIDTH-1:0] replacement_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sfq_pkg::STATUS_WIDTH-1:0]       status,
    output logic signed [sfq_pkg::FIELD_WIDTH-1:0] item_value,
    output logic                                   last_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] left_next;
    logic          busy_reg;
    logic          busy_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [sfq_pkg::STATUS_WIDTH-1:0] status_reg;
    logic [sfq_pkg::STATUS_WIDTH-1:0] status_next;
    logic [sfq_pkg::FIELD_WIDTH-1:0]  item_reg;
    logic [sfq_pkg::FIELD_WIDTH-1:0]  item_next;
    logic          last_reg;
    logic          last_next;

    logic                  in_take;
    logic                  out_free;
    logic                  found;
    logic                  empty;
    logic                  full;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] repl;
    sfq_pkg::cell_ctrl_t   ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]        match_chain;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg || !out_free;
    assign in_take  = in_valid && !in_stall;
    assign empty    = count_reg == '0;
    assign full     = count_reg >= FULL_COUNT;
    assign found    = match_chain[DEPTH];
    assign key      = DATA_WIDTH'(key_value);
    assign repl     = DATA_WIDTH'(replacement_value);

    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] behind;
            if (gi == DEPTH - 1)
            begin : g_end
                assign behind = cell_data[gi];
            end
            else
            begin : g_mid
                assign behind = cell_data[gi + 1];
            end
            sfq_cell #(
                .DATA_WIDTH  (DATA_WIDTH),
                .COUNT_WIDTH (CW),
                .INDEX       (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .key       (key),
                .repl      (repl),
                .head      (cell_data[0]),
                .behind    (behind),
                .match_in  (match_chain[gi]),
                .match_out (match_chain[gi + 1]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl           = '0;
        count_next     = count_reg;
        left_next      = left_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        item_next      = item_reg;
        last_next      = last_reg;

        if (in_take)
        begin
            unique case (req_type) inside
                sfq_pkg::REQ_INSERT:
                begin
                    out_valid_next = 1'b1;
                    item_next      = '0;
                    last_next      = 1'b1;
                    if (full)
                    begin
                        status_next = sfq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CW'(1);
                        status_next = sfq_pkg::ST_DONE;
                    end
                end
                sfq_pkg::REQ_SEARCH, sfq_pkg::REQ_MODIFY, sfq_pkg::REQ_DELETE:
                begin
                    out_valid_next = 1'b1;
                    item_next      = '0;
                    last_next      = 1'b1;
                    if (empty)
                    begin
                        status_next = sfq_pkg::ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = sfq_pkg::ST_NOT_FOUND;
                    end
                    else if (req_type == sfq_pkg::REQ_SEARCH)
                    begin
                        status_next = sfq_pkg::ST_FOUND;
                    end
                    else if (req_type == sfq_pkg::REQ_MODIFY)
                    begin
                        ctrl.modify = 1'b1;
                        status_next = sfq_pkg::ST_DONE;
                    end
                    else
                    begin
                        ctrl.remove = 1'b1;
                        count_next  = count_reg - CW'(1);
                        status_next = sfq_pkg::ST_DONE;
                    end
                end
                sfq_pkg::REQ_DISPLAY:
                begin
                    if (empty)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = sfq_pkg::ST_EMPTY;
                        item_next      = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        left_next = count_reg;
                    end
                end
                default:
                begin
                    // unknown kind: drop the request
                end
            endcase
        end
        else if (busy_reg && out_free)
        begin
            // emit the head entry and advance the ring by one cell
            ctrl.rotate    = 1'b1;
            out_valid_next = 1'b1;
            status_next    = sfq_pkg::ST_DONE;
            item_next      = sfq_pkg::FIELD_WIDTH'(signed'(cell_data[0]));
            last_next      = left_reg == CW'(1);
            left_next      = left_reg - CW'(1);
            busy_next      = left_reg != CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            left_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            left_reg      <= left_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_value  = signed'(item_reg);
    assign last_result = last_reg;

endmodule
